[rtl/bti_pkg.sv]
// ----------------------------------------------------------------------------
// bti_pkg
// Types and codes shared by the bilinear table interpolator modules.
// ----------------------------------------------------------------------------
package bti_pkg;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         index_x;
    logic [5:0]         index_y;
    logic signed [31:0] load_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } bti_in_t;

  typedef struct packed {
    logic signed [31:0] interpolated;
    logic               out_of_range;
    logic [5:0]         lower_x_index;
    logic [5:0]         lower_y_index;
  } bti_out_t;

  typedef enum logic [2:0] {
    OP_QUERY     = 3'd0,
    OP_WR_X      = 3'd1,
    OP_WR_Y      = 3'd2,
    OP_WR_TAB    = 3'd3,
    OP_QUERY_IDX = 3'd4
  } bti_op_t;

  typedef enum logic {
    REG_X_COUNT = 1'b0,
    REG_Y_COUNT = 1'b1
  } bti_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RNG_LO, S_RNG_HI, S_RNG_CHK, S_SRCH_RD, S_SRCH_CMP,
    S_CELL_LO, S_CELL_HI, S_CELL_CAP, S_DIV, S_MAC_RD, S_MAC_W,
    S_MAC_ACC, S_FINISH
  } bti_state_t;

  typedef enum logic [3:0] {
    C_NOP, C_LOAD, C_RNG_LO, C_RNG_HI, C_RNG_CHK, C_SRCH_RD, C_SRCH_CMP,
    C_CELL_LO, C_CELL_HI, C_CELL_CAP, C_DIV, C_MAC_RD, C_MAC_W,
    C_MAC_ACC, C_OUT
  } bti_cmd_t;

  typedef struct packed {
    bti_cmd_t   cmd;
    logic [1:0] term;
  } bti_ctl_t;

  typedef struct packed {
    logic oor;
    logic srch_done;
  } bti_sts_t;

  localparam logic [16:0] WEIGHT_ONE = 17'h10000;
  localparam int          DIV_STEPS  = 16;

endpackage

[rtl/bti_ctrl.sv]
// ----------------------------------------------------------------------------
// bti_ctrl
// Sequencer for request handling: range check, search, division, MAC.
// ----------------------------------------------------------------------------
module bti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        operation,
  input  bti_pkg::bti_sts_t sts,
  output bti_pkg::bti_ctl_t ctl,
  output logic              busy
);
  import bti_pkg::*;

  bti_state_t state_r, state_nxt;
  logic [3:0] div_cnt_r, div_cnt_nxt;
  logic [1:0] term_r, term_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
      term_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
      term_r    <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_QUERY) state_nxt = S_RNG_LO;
          else if (operation == OP_QUERY_IDX) state_nxt = S_CELL_LO;
        end
      end
      S_RNG_LO:   state_nxt = S_RNG_HI;
      S_RNG_HI:   state_nxt = S_RNG_CHK;
      S_RNG_CHK:  state_nxt = sts.oor ? S_FINISH : S_SRCH_RD;
      S_SRCH_RD:  state_nxt = sts.srch_done ? S_CELL_LO : S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = S_SRCH_RD;
      S_CELL_LO:  state_nxt = S_CELL_HI;
      S_CELL_HI:  state_nxt = S_CELL_CAP;
      S_CELL_CAP: state_nxt = S_DIV;
      S_DIV:      state_nxt = (div_cnt_r == 4'(DIV_STEPS - 1)) ? S_MAC_RD : S_DIV;
      S_MAC_RD:   state_nxt = S_MAC_W;
      S_MAC_W:    state_nxt = S_MAC_ACC;
      S_MAC_ACC:  state_nxt = (term_r == 2'd3) ? S_FINISH : S_MAC_RD;
      S_FINISH:   state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    div_cnt_nxt = (state_r == S_DIV) ? div_cnt_r + 4'd1 : '0;
    term_nxt    = (state_r == S_IDLE) ? 2'd0 :
                  (state_r == S_MAC_ACC) ? term_r + 2'd1 : term_r;
  end

  always_comb begin
    ctl.term = term_r;
    unique case (state_r)
      S_IDLE:     ctl.cmd = start ? C_LOAD : C_NOP;
      S_RNG_LO:   ctl.cmd = C_RNG_LO;
      S_RNG_HI:   ctl.cmd = C_RNG_HI;
      S_RNG_CHK:  ctl.cmd = C_RNG_CHK;
      S_SRCH_RD:  ctl.cmd = C_SRCH_RD;
      S_SRCH_CMP: ctl.cmd = C_SRCH_CMP;
      S_CELL_LO:  ctl.cmd = C_CELL_LO;
      S_CELL_HI:  ctl.cmd = C_CELL_HI;
      S_CELL_CAP: ctl.cmd = C_CELL_CAP;
      S_DIV:      ctl.cmd = C_DIV;
      S_MAC_RD:   ctl.cmd = C_MAC_RD;
      S_MAC_W:    ctl.cmd = C_MAC_W;
      S_MAC_ACC:  ctl.cmd = C_MAC_ACC;
      S_FINISH:   ctl.cmd = C_OUT;
      default:    ctl.cmd = C_NOP;
    endcase
    busy = (state_r != S_IDLE);
  end

endmodule

[rtl/bti_datapath.sv]
// ----------------------------------------------------------------------------
// bti_datapath
// Grid and table memories, count registers, search, weight dividers and MAC.
// ----------------------------------------------------------------------------
module bti_datapath #(
  parameter int MAX_X_POINTS = 64,
  parameter int MAX_Y_POINTS = 64,
  parameter int VALUE_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data,
  input  bti_pkg::bti_in_t  in_item,
  input  bti_pkg::bti_ctl_t ctl,
  output bti_pkg::bti_sts_t sts,
  output logic              out_valid,
  output bti_pkg::bti_out_t out_item
);
  import bti_pkg::*;

  localparam int AXW = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
  localparam int AYW = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
  localparam int TW  = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
  localparam int VB  = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  logic signed [31:0] x_mem [MAX_X_POINTS];
  logic signed [31:0] y_mem [MAX_Y_POINTS];
  logic signed [31:0] t_mem [MAX_X_POINTS * MAX_Y_POINTS];

  logic [6:0] x_cnt_r, y_cnt_r;
  logic signed [31:0] x_rd_r, y_rd_r, t_rd_r;
  logic signed [31:0] cx_r, cy_r, xlo_r, ylo_r;
  logic [AXW-1:0] lx_r, hx_r, x_mid, x_addr;
  logic [AYW-1:0] ly_r, hy_r, y_mid, y_addr;
  logic [TW-1:0]  t_addr;
  logic oor_r, oor_now, x_done, y_done;
  logic [33:0] rx_r, ry_r, spx_r, spy_r, rx_sh, ry_sh;
  logic [15:0] qx_r, qy_r;
  logic wzx_r, wsx_r, wzy_r, wsy_r;
  logic [16:0] wx, wy, wa, wb;
  logic [33:0] wprod_r;
  logic signed [66:0] acc_r;
  logic signed [32:0] dx, dy, sx, sy;
  logic signed [31:0] lv;
  int nx, ny, clx, cly;
  logic out_valid_r;
  bti_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_cnt_r <= 7'd64;
      y_cnt_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == REG_X_COUNT) x_cnt_r <= cfg_data;
      else y_cnt_r <= cfg_data;
    end
  end

  always_comb begin
    nx = (x_cnt_r < 7'd2) ? 2 : (int'(x_cnt_r) > MAX_X_POINTS) ? MAX_X_POINTS : int'(x_cnt_r);
    ny = (y_cnt_r < 7'd2) ? 2 : (int'(y_cnt_r) > MAX_Y_POINTS) ? MAX_Y_POINTS : int'(y_cnt_r);
    clx = (int'(in_item.index_x) > nx - 2) ? nx - 2 : int'(in_item.index_x);
    cly = (int'(in_item.index_y) > ny - 2) ? ny - 2 : int'(in_item.index_y);
    lv = 32'($signed(in_item.load_value[VB-1:0]));
  end

  // search midpoints and done flags
  always_comb begin
    x_mid  = AXW'(({1'b0, lx_r} + {1'b0, hx_r}) >> 1);
    y_mid  = AYW'(({1'b0, ly_r} + {1'b0, hy_r}) >> 1);
    x_done = ({1'b0, hx_r} - {1'b0, lx_r}) <= (AXW + 1)'(1);
    y_done = ({1'b0, hy_r} - {1'b0, ly_r}) <= (AYW + 1)'(1);
    sts.srch_done = x_done && y_done;
    oor_now = (cx_r < xlo_r) || (cx_r > x_rd_r) || (cy_r < ylo_r) || (cy_r > y_rd_r);
    sts.oor = oor_now;
  end

  always_comb begin
    case (ctl.cmd)
      C_RNG_LO:  begin x_addr = '0;              y_addr = '0;              end
      C_RNG_HI:  begin x_addr = AXW'(nx - 1);    y_addr = AYW'(ny - 1);    end
      C_SRCH_RD: begin x_addr = x_mid;           y_addr = y_mid;           end
      C_CELL_HI: begin x_addr = lx_r + AXW'(1);  y_addr = ly_r + AYW'(1);  end
      default:   begin x_addr = lx_r;            y_addr = ly_r;            end
    endcase
    t_addr = TW'((int'(lx_r) + int'(ctl.term[0])) * MAX_Y_POINTS
                 + int'(ly_r) + int'(ctl.term[1]));
  end

  // memories
  always_ff @(posedge clk) begin
    if (ctl.cmd == C_LOAD && in_item.operation == OP_WR_X
        && int'(in_item.index_x) < MAX_X_POINTS)
      x_mem[AXW'(in_item.index_x)] <= lv;
    x_rd_r <= x_mem[x_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == C_LOAD && in_item.operation == OP_WR_Y
        && int'(in_item.index_y) < MAX_Y_POINTS)
      y_mem[AYW'(in_item.index_y)] <= lv;
    y_rd_r <= y_mem[y_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == C_LOAD && in_item.operation == OP_WR_TAB
        && int'(in_item.index_x) < MAX_X_POINTS && int'(in_item.index_y) < MAX_Y_POINTS)
      t_mem[TW'(int'(in_item.index_x) * MAX_Y_POINTS + int'(in_item.index_y))] <= lv;
    t_rd_r <= t_mem[t_addr];
  end

  // weights
  always_comb begin
    dx = $signed({cx_r[31], cx_r}) - $signed({xlo_r[31], xlo_r});
    sx = $signed({x_rd_r[31], x_rd_r}) - $signed({xlo_r[31], xlo_r});
    dy = $signed({cy_r[31], cy_r}) - $signed({ylo_r[31], ylo_r});
    sy = $signed({y_rd_r[31], y_rd_r}) - $signed({ylo_r[31], ylo_r});
    rx_sh = {rx_r[32:0], 1'b0};
    ry_sh = {ry_r[32:0], 1'b0};
    wx = wzx_r ? 17'd0 : wsx_r ? WEIGHT_ONE : {1'b0, qx_r};
    wy = wzy_r ? 17'd0 : wsy_r ? WEIGHT_ONE : {1'b0, qy_r};
    wa = ctl.term[0] ? wx : WEIGHT_ONE - wx;
    wb = ctl.term[1] ? wy : WEIGHT_ONE - wy;
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      C_LOAD: begin
        cx_r  <= in_item.coord_x;
        cy_r  <= in_item.coord_y;
        oor_r <= 1'b0;
        if (in_item.operation == OP_QUERY_IDX) begin
          lx_r <= AXW'(clx);
          ly_r <= AYW'(cly);
        end else begin
          lx_r <= '0;
          ly_r <= '0;
          hx_r <= AXW'(nx - 1);
          hy_r <= AYW'(ny - 1);
        end
      end
      C_RNG_HI, C_CELL_HI: begin
        xlo_r <= x_rd_r;
        ylo_r <= y_rd_r;
      end
      C_RNG_CHK: oor_r <= oor_now;
      C_SRCH_CMP: begin
        if (!x_done) begin
          if (x_rd_r < cx_r) lx_r <= x_mid;
          else hx_r <= x_mid;
        end
        if (!y_done) begin
          if (y_rd_r < cy_r) ly_r <= y_mid;
          else hy_r <= y_mid;
        end
      end
      C_CELL_CAP: begin
        wzx_r <= (sx <= 33'sd0) || (dx <= 33'sd0);
        wsx_r <= dx >= sx;
        wzy_r <= (sy <= 33'sd0) || (dy <= 33'sd0);
        wsy_r <= dy >= sy;
        rx_r  <= {1'b0, dx};
        spx_r <= {1'b0, sx};
        ry_r  <= {1'b0, dy};
        spy_r <= {1'b0, sy};
        qx_r  <= '0;
        qy_r  <= '0;
        acc_r <= '0;
      end
      C_DIV: begin
        if (rx_sh >= spx_r) begin
          rx_r <= rx_sh - spx_r;
          qx_r <= {qx_r[14:0], 1'b1};
        end else begin
          rx_r <= rx_sh;
          qx_r <= {qx_r[14:0], 1'b0};
        end
        if (ry_sh >= spy_r) begin
          ry_r <= ry_sh - spy_r;
          qy_r <= {qy_r[14:0], 1'b1};
        end else begin
          ry_r <= ry_sh;
          qy_r <= {qy_r[14:0], 1'b0};
        end
      end
      C_MAC_W:   wprod_r <= {17'b0, wa} * {17'b0, wb};
      C_MAC_ACC: acc_r <= acc_r + $signed({{35{t_rd_r[31]}}, t_rd_r})
                                  * $signed({33'b0, wprod_r});
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= (ctl.cmd == C_OUT);
    if (ctl.cmd == C_OUT) begin
      out_r.interpolated  <= oor_r ? 32'sd0 : acc_r[63:32];
      out_r.out_of_range  <= oor_r;
      out_r.lower_x_index <= oor_r ? 6'd0 : 6'(lx_r);
      out_r.lower_y_index <= oor_r ? 6'd0 : 6'(ly_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[rtl/bilinear_table_interpolator.sv]
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Bilinear interpolation over a loaded x grid, y grid and value table.
// ----------------------------------------------------------------------------
// Writes (grid points, table entries) leave busy low. A query with given
// indices skips range check and search and goes to the cell reads, weight
// division and MAC; a search query checks the range, then searches both axes
// at once until both are done (6 steps at 64 points); out-of-range queries
// finish after the range check. Query time is set by the search step (read
// state, then compare state) on the single grid read ports, the 16-step
// bit-serial weight dividers and the four table reads feeding one shared
// multiply-accumulate. busy is high while a query runs; the result appears
// on out_item with out_valid for a single cycle and cannot be stalled.
module bilinear_table_interpolator #(
  parameter int MAX_X_POINTS = 64,
  parameter int MAX_Y_POINTS = 64,
  parameter int VALUE_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bti_pkg::bti_in_t  in_item,
  output logic              out_valid,
  output bti_pkg::bti_out_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);
  import bti_pkg::*;

  bti_ctl_t ctl;
  bti_sts_t sts;

  assign cfg_ready = 1'b1;

  bti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_item.operation),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy)
  );

  bti_datapath #(
    .MAX_X_POINTS (MAX_X_POINTS),
    .MAX_Y_POINTS (MAX_Y_POINTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[rtl/bti_checker.sv]
// ----------------------------------------------------------------------------
// bti_checker
// Port-level checks for the bilinear table interpolator.
// ----------------------------------------------------------------------------
module bti_port_checks (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input bti_pkg::bti_in_t  in_item,
  input logic              out_valid
);
  import bti_pkg::*;

  logic acc_query, acc_other;
  assign acc_query = start && !busy &&
                     (in_item.operation == OP_QUERY || in_item.operation == OP_QUERY_IDX);
  assign acc_other = start && !busy && !(in_item.operation == OP_QUERY ||
                     in_item.operation == OP_QUERY_IDX);

  a_reset: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or result after reset");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_query |=> busy)
    else $error("query request did not start");
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    acc_other |=> !busy && !out_valid)
    else $error("write request held the block or made a result");
  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result not at end of query");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind bilinear_table_interpolator bti_port_checks u_bti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid)
);
